// File: sv/top_k_sorted_insert_top_macros.svh
// Assertion macros used by the checker of the ranked table block.
`ifndef TOP_K_SORTED_INSERT_TOP_MACROS_SVH
`define TOP_K_SORTED_INSERT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define TKSI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ranked table check failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define TKSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ranked table check failed");

`endif

// File: sv/tksi_pkg.sv
// Shared types and constants of the ranked table block.
package tksi_pkg;

  localparam int unsigned TableEntriesDef = 10;
  localparam int unsigned IndexW          = 4;
  localparam int unsigned DateW           = 32;
  localparam int unsigned ScoreW          = 32;
  localparam int unsigned TimeW           = 31;

  localparam logic CmdSubmit = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef struct packed {
    logic        [DateW-1:0]  date;
    logic signed [ScoreW-1:0] score;
    logic        [TimeW-1:0]  run_time;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StShift,
    StWrite,
    StResp
  } state_e;

endpackage

// File: sv/tksi_intf.sv
// Word channels of the ranked table block: request and response.
interface tksi_req_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic        [tksi_pkg::IndexW-1:0]  entry_index;
  logic        [tksi_pkg::DateW-1:0]   new_date;
  logic signed [tksi_pkg::ScoreW-1:0]  new_score;
  logic        [tksi_pkg::TimeW-1:0]   new_time;

  modport source (output valid, command, entry_index, new_date, new_score, new_time,
                  input ready);
  modport sink   (input valid, command, entry_index, new_date, new_score, new_time,
                  output ready);
endinterface

interface tksi_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic        [tksi_pkg::IndexW-1:0]  insert_position;
  logic        [tksi_pkg::DateW-1:0]   read_date;
  logic signed [tksi_pkg::ScoreW-1:0]  read_score;
  logic        [tksi_pkg::TimeW-1:0]   read_time;

  modport source (output valid, accepted, insert_position, read_date, read_score, read_time,
                  input ready);
  modport sink   (input valid, accepted, insert_position, read_date, read_score, read_time,
                  output ready);
endinterface

// File: sv/tksi_cmp.sv
// Shared rank comparator: does the candidate entry outrank a stored one.
module tksi_cmp (
  input  tksi_pkg::entry_t cand_i,
  input  tksi_pkg::entry_t stored_i,
  output logic             beats_o
);

  logic score_gt;
  logic score_eq;
  logic time_lt;

  assign score_gt = $signed(cand_i.score) > $signed(stored_i.score);
  assign score_eq = cand_i.score == stored_i.score;
  assign time_lt  = cand_i.run_time < stored_i.run_time;
  assign beats_o  = score_gt || (score_eq && time_lt);

endmodule

// File: sv/tksi_tab.sv
// Entry memory of the ranked table, one read and one write port, reset through valid bits.
module tksi_tab #(
  parameter  int unsigned Depth = tksi_pkg::TableEntriesDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output tksi_pkg::entry_t   rd_data_o,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  tksi_pkg::entry_t   wr_data_i
);

  tksi_pkg::entry_t mem_q [Depth];
  tksi_pkg::entry_t rd_q;
  logic [Depth-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: sv/top_k_sorted_insert_top.sv
// Ranked table top level: sequencer, entry memory and shared comparator.
//
// The block keeps TABLE_ENTRIES ranked entries (date, signed score, time), all zero after
// reset. A submit word scans the table from position 0 and inserts the new entry at the
// first position whose score it beats, or whose score it equals with a strictly smaller
// time; the entries below move down one place and the last one drops out. If no position
// qualifies the entry is rejected and the table stays as it was. A read word returns the
// entry at entry_index, or zeros when the index lies beyond the table. Every request word
// gives exactly one response word. The block works on one request at a time and is not
// ready while it does. A read fetches the entry in its read step and then loads the
// response register. A submit scans the positions in turn, each read judged by the
// comparator once its data is back; unless the entry goes in at the last position, it
// then moves the entries below down one place each, from the bottom up; then it writes
// the new entry and loads the response register. A rejected entry loads the response
// register once the scan ends. The block is ready for the next request word in the cycle
// after the response register is loaded. This sequence comes from the single read and
// single write port of the entry memory and from the one comparator that the scan shares.
// The response sits in an output register, so a new request is taken while an earlier
// response still waits to be collected; a finished request waits in its last step only
// when that register is still full.
module top_k_sorted_insert_top #(
  parameter int unsigned TABLE_ENTRIES = tksi_pkg::TableEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tksi_req_if.sink   req_i,
  tksi_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_ENTRIES - 1);

  tksi_pkg::state_e st_q, st_d;

  // Captured request word.
  tksi_pkg::entry_t                item_q;
  logic                            cmd_q;
  logic [tksi_pkg::IndexW-1:0]     index_q;

  // Sequencer counters: next address to read, address of the data held in the memory
  // read register, insertion position and scan/shift bookkeeping.
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] cmp_q, cmp_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             pend_q, pend_d;
  logic             rd_done_q, rd_done_d;
  logic             hit_q, hit_d;

  // Response register.
  logic                            out_vld_q, out_vld_d;
  logic                            acc_q;
  logic [tksi_pkg::IndexW-1:0]     ipos_q;
  tksi_pkg::entry_t                odat_q;

  logic             in_fire;
  logic             load_out;
  logic             in_range;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  tksi_pkg::entry_t rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  tksi_pkg::entry_t wr_data;
  logic             beats;

  assign req_i.ready = (st_q == tksi_pkg::StIdle);
  assign in_fire     = req_i.valid && req_i.ready;
  assign in_range    = 32'(index_q) < TABLE_ENTRIES;

  tksi_tab #(
    .Depth (TABLE_ENTRIES)
  ) u_tab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  tksi_cmp u_cmp (
    .cand_i   (item_q),
    .stored_i (rd_data),
    .beats_o  (beats)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= tksi_pkg::StIdle;
      idx_q     <= '0;
      cmp_q     <= '0;
      pos_q     <= '0;
      pend_q    <= 1'b0;
      rd_done_q <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      cmp_q     <= cmp_d;
      pos_q     <= pos_d;
      pend_q    <= pend_d;
      rd_done_q <= rd_done_d;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q          <= req_i.command;
      index_q        <= req_i.entry_index;
      item_q.date     <= req_i.new_date;
      item_q.score    <= req_i.new_score;
      item_q.run_time <= req_i.new_time;
    end
    if (load_out) begin
      acc_q  <= hit_q;
      ipos_q <= hit_q ? tksi_pkg::IndexW'(pos_q) : '0;
      if (cmd_q == tksi_pkg::CmdRead && in_range) begin
        odat_q <= rd_data;
      end else begin
        odat_q <= '0;
      end
    end
  end

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    cmp_d     = cmp_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    rd_done_d = rd_done_q;
    hit_d     = hit_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = pos_q;
    wr_data   = item_q;
    load_out  = 1'b0;

    case (st_q)
      tksi_pkg::StIdle: begin
        if (in_fire) begin
          idx_d     = '0;
          pend_d    = 1'b0;
          rd_done_d = 1'b0;
          hit_d     = 1'b0;
          st_d      = (req_i.command == tksi_pkg::CmdRead) ? tksi_pkg::StRead
                                                           : tksi_pkg::StScan;
        end
      end

      tksi_pkg::StRead: begin
        rd_en   = in_range;
        rd_addr = AddrW'(index_q);
        st_d    = tksi_pkg::StResp;
      end

      // One read issued per cycle; the comparator judges the entry read the cycle before.
      tksi_pkg::StScan: begin
        if (pend_q && beats) begin
          pos_d     = cmp_q;
          pend_d    = 1'b0;
          rd_done_d = 1'b0;
          if (cmp_q == LastAddr) begin
            st_d = tksi_pkg::StWrite;
          end else begin
            idx_d = LastAddr - AddrW'(1);
            st_d  = tksi_pkg::StShift;
          end
        end else if (pend_q && cmp_q == LastAddr) begin
          st_d = tksi_pkg::StResp;
        end else if (!rd_done_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q;
          cmp_d   = idx_q;
          pend_d  = 1'b1;
          if (idx_q == LastAddr) begin
            rd_done_d = 1'b1;
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end

      // Move entries down from the bottom up: read one, write the one read before.
      tksi_pkg::StShift: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = cmp_q + AddrW'(1);
          wr_data = rd_data;
        end
        if (!rd_done_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q;
          cmp_d   = idx_q;
          pend_d  = 1'b1;
          if (idx_q == pos_q) begin
            rd_done_d = 1'b1;
          end else begin
            idx_d = idx_q - AddrW'(1);
          end
        end else begin
          pend_d = 1'b0;
          st_d   = tksi_pkg::StWrite;
        end
      end

      tksi_pkg::StWrite: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = item_q;
        hit_d   = 1'b1;
        st_d    = tksi_pkg::StResp;
      end

      tksi_pkg::StResp: begin
        if (!out_vld_q || rsp_o.ready) begin
          load_out = 1'b1;
          st_d     = tksi_pkg::StIdle;
        end
      end

      default: begin
        st_d = tksi_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.accepted        = acc_q;
  assign rsp_o.insert_position = ipos_q;
  assign rsp_o.read_date       = odat_q.date;
  assign rsp_o.read_score      = odat_q.score;
  assign rsp_o.read_time       = odat_q.run_time;

endmodule

// File: sv/tksi_chk.sv
// Port-level checker of the ranked table block and its binding to the top level.
`include "top_k_sorted_insert_top_macros.svh"

module tksi_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] open_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Words taken in but whose response has not yet been collected.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_fire && !out_fire) begin
      open_q <= open_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      open_q <= open_q - 2'd1;
    end
  end

  `TKSI_ASSERT_NEXT(a_rsp_held, out_valid_i && !out_ready_i, out_valid_i)
  `TKSI_ASSERT_NEXT(a_busy_after_take, in_fire, !in_ready_i)
  `TKSI_ASSERT_NOW(a_no_spurious_rsp, out_valid_i, open_q != 2'd0)
  `TKSI_ASSERT_NOW(a_no_overrun, open_q == 2'd2, !in_ready_i)

endmodule

bind top_k_sorted_insert_top tksi_chk u_tksi_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready)
);

// File: verif/top_k_sorted_insert_top_tb.sv
// Self-checking testbench of the ranked table block: directed words, then random traffic.
module top_k_sorted_insert_top_tb;
  import tksi_pkg::*;

  localparam int unsigned TableEntries = TableEntriesDef;
  localparam int unsigned RandomItems  = 900;
  localparam int unsigned CalmTail     = 150;   // final words sent with no idling at all
  localparam int unsigned LongStall    = 400;   // cycles the response side holds off once
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned NumRows      = 24;

  // One response word as the block should return it.
  typedef struct packed {
    logic                     accepted;
    logic        [IndexW-1:0] position;
    logic        [DateW-1:0]  date;
    logic signed [ScoreW-1:0] score;
    logic        [TimeW-1:0]  run_time;
  } rank_reply_t;

  // One directed word; the reply is typed in only where fixed is set.
  typedef struct packed {
    logic                     cmd;
    logic        [IndexW-1:0] idx;
    logic        [DateW-1:0]  date;
    logic signed [ScoreW-1:0] score;
    logic        [TimeW-1:0]  run_time;
    bit                       fixed;
    rank_reply_t              reply;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  tksi_req_if req_if ();
  tksi_rsp_if rsp_if ();

  top_k_sorted_insert_top #(
    .TABLE_ENTRIES(TableEntries)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the ranked table and the replies still to come back.
  entry_t      ranking [TableEntries];
  rank_reply_t pending_replies [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          stall_rsp_req;
  bit          no_idle;

  stim_row_t plan [NumRows] = '{
    // After reset every position reads back as zero, even beyond the table.
    '{CmdRead,   4'd0,  32'h0,         32'h0,         31'h0,         1'b1, '0},
    '{CmdRead,   4'd9,  32'h0,         32'h0,         31'h0,         1'b1, '0},
    '{CmdRead,   4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, '0},
    // An equal score with an equal or larger time never qualifies; nor does the lowest score.
    '{CmdSubmit, 4'd0,  32'h1,         32'h0,         31'h0,         1'b1, '0},
    '{CmdSubmit, 4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 31'h0,         1'b1, '0},
    '{CmdSubmit, 4'd5,  32'h2,         32'h0,         31'h7FFF_FFFF, 1'b1, '0},
    // The highest score goes straight to the top.
    '{CmdSubmit, 4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1,
      '{1'b1, 4'd0, 32'h0, 32'h0, 31'h0}},
    '{CmdRead,   4'd0,  32'h0,         32'h0,         31'h0,         1'b1,
      '{1'b0, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF}},
    // Same score with a smaller time overtakes and pushes the old top down one place.
    '{CmdSubmit, 4'd0,  32'h0,         32'h7FFF_FFFF, 31'h0,         1'b1,
      '{1'b1, 4'd0, 32'h0, 32'h0, 31'h0}},
    '{CmdRead,   4'd1,  32'h0,         32'h0,         31'h0,         1'b1,
      '{1'b0, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF}},
    // Ties, a rejected negative score and enough inserts to fill the table.
    '{CmdSubmit, 4'd3,  32'd10,        32'd1,         31'd5,         1'b0, '0},
    '{CmdSubmit, 4'd3,  32'd11,        32'd1,         31'd5,         1'b0, '0},
    '{CmdSubmit, 4'd3,  32'd12,        32'd1,         31'd4,         1'b0, '0},
    '{CmdSubmit, 4'd3,  32'd13,        32'hFFFF_FFFF, 31'd0,         1'b0, '0},
    '{CmdSubmit, 4'd3,  32'd14,        32'd0,         31'd0,         1'b0, '0},
    '{CmdSubmit, 4'd7,  32'd15,        32'd50,        31'd9,         1'b0, '0},
    '{CmdSubmit, 4'd7,  32'd16,        32'd50,        31'd9,         1'b0, '0},
    '{CmdSubmit, 4'd7,  32'd17,        32'd2,         31'd1,         1'b0, '0},
    '{CmdSubmit, 4'd7,  32'd18,        32'd3,         31'd1,         1'b0, '0},
    '{CmdSubmit, 4'd7,  32'd19,        32'd40,        31'd2,         1'b0, '0},
    '{CmdRead,   4'd9,  32'h0,         32'h0,         31'h0,         1'b0, '0},
    // Just past the last position the read gives zeros.
    '{CmdRead,   4'd10, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, '0},
    '{CmdSubmit, 4'd0,  32'd20,        32'd1,         31'd6,         1'b0, '0},
    '{CmdRead,   4'd4,  32'h0,         32'h0,         31'h0,         1'b0, '0}
  };

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Works out the reply to one word and updates the shadow table as the block should.
  function automatic rank_reply_t rank_apply(logic cmd, logic [IndexW-1:0] idx,
                                             entry_t cand);
    rank_reply_t r;
    int          slot;
    int          i;
    r    = '0;
    slot = -1;
    if (cmd == CmdRead) begin
      if (idx < TableEntries) begin
        r.date     = ranking[idx].date;
        r.score    = ranking[idx].score;
        r.run_time = ranking[idx].run_time;
      end
    end else begin
      for (i = 0; i < TableEntries; i++) begin
        if (slot < 0 && (cand.score > ranking[i].score ||
            (cand.score == ranking[i].score && cand.run_time < ranking[i].run_time))) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        for (i = TableEntries - 1; i > slot; i--) begin
          ranking[i] = ranking[i-1];
        end
        ranking[slot] = cand;
        r.accepted    = 1'b1;
        r.position    = 4'(slot);
      end
    end
    return r;
  endfunction

  // Offers one request word from a falling edge and returns at the falling edge after it
  // was taken, with valid still high so that a following word goes out without a gap.
  task automatic send_word(logic cmd, logic [IndexW-1:0] idx, entry_t fresh, bit typed,
                           rank_reply_t typed_reply);
    rank_reply_t predicted;
    req_if.command     = cmd;
    req_if.entry_index = idx;
    req_if.new_date    = fresh.date;
    req_if.new_score   = fresh.score;
    req_if.new_time    = fresh.run_time;
    req_if.valid       = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = rank_apply(cmd, idx, fresh);
    pending_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk_i);
  endtask

  task automatic idle_req(int unsigned cycles);
    req_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain_replies();
    req_if.valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  // Scores follow a slowly rising base so that inserts keep landing all through the run;
  // a few full-width negative scores exercise the upper bits and the rejection path.
  task automatic make_random_word(int unsigned n, output logic cmd,
                                  output logic [IndexW-1:0] idx, output entry_t fresh);
    int base;
    base          = int'(n / 3);
    cmd           = ($urandom_range(0, 99) < 35) ? CmdRead : CmdSubmit;
    fresh.date    = $urandom;
    fresh.run_time = ($urandom_range(0, 99) < 70) ? 31'($urandom_range(0, 15)) : 31'($urandom);
    if ($urandom_range(0, 99) < 5) begin
      fresh.score = {1'b1, 31'($urandom)};
    end else begin
      fresh.score = 32'(base + int'($urandom_range(0, 40)) - 20);
    end
    if (cmd == CmdRead && $urandom_range(0, 99) < 70) begin
      idx = 4'($urandom_range(0, TableEntries - 1));
    end else begin
      idx = 4'($urandom_range(0, 15));
    end
  endtask

  // Request side: reset, directed table, then random words with bursts of idling.
  initial begin : req_drive
    int unsigned n;
    int unsigned gap_pct;
    logic        cmd;
    logic [IndexW-1:0] idx;
    entry_t      fresh;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.command     = CmdSubmit;
    req_if.entry_index = '0;
    req_if.new_date    = '0;
    req_if.new_score   = '0;
    req_if.new_time    = '0;
    stall_rsp_req      = 1'b0;
    no_idle            = 1'b0;
    gap_pct            = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (n = 0; n < NumRows; n++) begin
      fresh = '{plan[n].date, plan[n].score, plan[n].run_time};
      send_word(plan[n].cmd, plan[n].idx, fresh, plan[n].fixed, plan[n].reply);
      if ($urandom_range(0, 99) < 30) idle_req($urandom_range(1, 14));
    end
    drain_replies();

    for (n = 0; n < RandomItems; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      // Hold the response side off for a long stretch while words keep coming, so the
      // block fills up and has to refuse further requests.
      if (n == 300) stall_rsp_req = 1'b1;
      // Let everything in flight come back before carrying on.
      if (n == 600) drain_replies();
      if (n == RandomItems - CalmTail) no_idle = 1'b1;
      make_random_word(n, cmd, idx, fresh);
      send_word(cmd, idx, fresh, 1'b0, '0);
      if (!no_idle && !(n >= 300 && n < 350) && $urandom_range(0, 99) < gap_pct) begin
        idle_req($urandom_range(1, 14));
      end
    end
    req_if.valid = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * TableEntries + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Response side: ready drops in random bursts, once for a long stretch, never at the end.
  initial begin : rsp_ready_drive
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned cyc;
    hold_left    = 0;
    stall_pct    = 0;
    cyc          = 0;
    rsp_if.ready = 1'b0;
    while (!rst_ni) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (stall_rsp_req) begin
        stall_rsp_req = 1'b0;
        hold_left     = LongStall;
      end
      if (no_idle) hold_left = 0;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
        hold_left    = $urandom_range(1, 14) - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Each response word is held against the oldest reply still awaited.
  always @(posedge clk_i) begin : rsp_check
    rank_reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response expected none actual %b %h %h %h %h", $time,
                 rsp_if.accepted, rsp_if.insert_position, rsp_if.read_date,
                 rsp_if.read_score, rsp_if.read_time);
      end else begin
        want = pending_replies.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(rsp_if.accepted));
        check_field("insert_position", 32'(want.position), 32'(rsp_if.insert_position));
        check_field("read_date", want.date, rsp_if.read_date);
        check_field("read_score", want.score, rsp_if.read_score);
        check_field("read_time", 32'(want.run_time), 32'(rsp_if.read_time));
      end
    end
  end

  initial begin : shadow_reset
    int i;
    mismatches  = 0;
    cycle_count = 0;
    for (i = 0; i < TableEntries; i++) ranking[i] = '0;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+sv
sv/tksi_pkg.sv
sv/tksi_intf.sv
sv/tksi_cmp.sv
sv/tksi_tab.sv
sv/top_k_sorted_insert_top.sv
sv/tksi_chk.sv
verif/top_k_sorted_insert_top_tb.sv
